>>> hdl/bech32d_pkg.sv
// ----------------------------------------------------------------------------
// bech32d_pkg
// Shared types, constants and checksum helpers for the streaming bech32
// string decoder.
// ----------------------------------------------------------------------------
package bech32d_pkg;

  localparam int PREFIX_MAX_CHARS = 8;
  localparam int MAX_STRING_CHARS = 1024;

  // Character count saturates at MAX_STRING_CHARS + 1.
  localparam int CHAR_COUNT_W = $clog2(MAX_STRING_CHARS + 2);
  localparam int DELAY_DEPTH  = 6;
  localparam int DELAY_FILL_W = $clog2(DELAY_DEPTH + 1);
  localparam int PLEN_W       = $clog2(PREFIX_MAX_CHARS + 1);
  localparam int SEED_STEP_W  = $clog2(2 * PREFIX_MAX_CHARS + 2);
  localparam int BYTE_COUNT_W = 13;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_PREFIX_CHARS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PREFIX_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_OUT_BYTES = 2'd2;

  localparam logic [7:0] SEPARATOR_CHAR = 8'h31;  // '1'

  localparam logic [29:0] GEN_POLY [5] = '{
    30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
  };

  localparam logic [7:0] ALPHABET [32] = '{
    "q", "p", "z", "r", "y", "9", "x", "8",
    "g", "f", "2", "t", "v", "d", "w", "0",
    "s", "3", "j", "n", "5", "4", "k", "h",
    "c", "e", "6", "m", "u", "a", "7", "l"
  };

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_string;
  } src_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic       failed;
  } dst_item_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] value;
  } symbol_t;

  // One BCH polymod step: shift in a 5-bit symbol, fold the top bits back.
  function automatic logic [29:0] poly_step(input logic [29:0] acc, input logic [4:0] v);
    logic [4:0]  top;
    logic [29:0] r;
    top = acc[29:25];
    r   = {acc[24:0], v};
    for (int j = 0; j < 5; j++) begin
      if (top[j]) begin
        r = r ^ GEN_POLY[j];
      end
    end
    return r;
  endfunction

  // Map an ASCII character to its 5-bit alphabet value.
  function automatic symbol_t symbol_lookup(input logic [7:0] c);
    symbol_t s;
    s = '0;
    for (int i = 0; i < 32; i++) begin
      if (ALPHABET[i] == c) begin
        s.hit   = 1'b1;
        s.value = 5'(i);
      end
    end
    return s;
  endfunction

endpackage

>>> hdl/bech32_string_decoder_core.sv
// ----------------------------------------------------------------------------
// bech32_string_decoder_core
// Streaming bech32 decoder: one character in, one result out per transfer.
// ----------------------------------------------------------------------------
//
// Usage:
//   src channel: one ASCII character per transfer (src_data.in_char), with
//   end_of_string set on the last one. A transfer completes when src_valid
//   is high and src_stall is low.
//   dst channel: exactly one result per accepted character, in order. It
//   carries a decoded byte when byte_valid is set; the result of the last
//   character has string_done set and failed telling good from bad.
//   cfg port: write cfg_data to register cfg_index when cfg_write is high.
//   Write only while no string is in flight.
// Throughput: one character per cycle while src_stall is low; each result
//   is registered into the output queue on its transfer and reaches dst once
//   earlier results are taken. The two-entry queue holds results that dst has
//   not taken yet; a stall on dst reaches src_stall once both entries are full.
// Reset and configuration: after reset and after any write to a known
//   register, the prefix seed sequencer takes one polymod step per cycle
//   through high parts, a zero and low parts, with src_stall high meanwhile.
// Receiver stall: results queue in the two entries; src_stall rises only
//   when both hold results not yet transferred.
// ----------------------------------------------------------------------------
module bech32_string_decoder_core
  import bech32d_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   src_valid,
  output logic                   src_stall,
  input  src_item_t              src_data,
  output logic                   dst_valid,
  input  logic                   dst_stall,
  output dst_item_t              dst_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers
  logic [63:0]             prefix_chars;
  logic [3:0]              prefix_length;
  logic [BYTE_COUNT_W-1:0] max_out_bytes;

  // Seed sequencer
  logic                   seed_busy;
  logic [SEED_STEP_W-1:0] seed_step;
  logic [29:0]            prefix_seed;

  // String state
  logic [29:0]             checksum_acc;
  logic [CHAR_COUNT_W-1:0] char_count;
  logic [4:0]              symbol_delay [DELAY_DEPTH];
  logic [DELAY_FILL_W-1:0] delay_fill;
  logic [11:0]             bit_acc;
  logic [3:0]              bit_count;
  logic [BYTE_COUNT_W-1:0] byte_count;
  logic                    error_flag;

  // Output queue
  dst_item_t  out_slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] out_count;

  logic [PLEN_W-1:0] plen;
  logic              accept;
  logic              pop;

  // Clamp prefix length to the supported maximum.
  assign plen = (prefix_length > 4'(PREFIX_MAX_CHARS)) ? PLEN_W'(PREFIX_MAX_CHARS)
                                                       : PLEN_W'(prefix_length);

  assign src_stall = seed_busy || (out_count == 2'd2);
  assign accept    = src_valid && !src_stall;
  assign dst_valid = (out_count != 2'd0);
  assign pop       = dst_valid && !dst_stall;
  assign dst_data  = out_slot[rd_ptr];

  // --------------------------------------------------------------------------
  // Configuration writes; any write to a known register restarts the seed.
  // --------------------------------------------------------------------------
  logic cfg_hit;

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_write) begin
      unique case (cfg_index)
        CFG_PREFIX_CHARS, CFG_PREFIX_LENGTH, CFG_MAX_OUT_BYTES: cfg_hit = 1'b1;
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_chars  <= '0;
      prefix_length <= 4'd1;
      max_out_bytes <= BYTE_COUNT_W'(4096);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PREFIX_CHARS:  prefix_chars  <= cfg_data;
        CFG_PREFIX_LENGTH: prefix_length <= cfg_data[3:0];
        CFG_MAX_OUT_BYTES: max_out_bytes <= cfg_data[BYTE_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Seed sequencer: high parts of the prefix, a zero, then the low parts.
  // --------------------------------------------------------------------------
  logic [SEED_STEP_W-1:0] seed_plen;
  logic [SEED_STEP_W-1:0] seed_low_idx;
  logic [2:0]             seed_byte_idx;
  logic [7:0]             seed_byte;
  logic [4:0]             seed_sym;

  always_comb begin
    seed_plen     = SEED_STEP_W'(plen);
    seed_low_idx  = seed_step - seed_plen - SEED_STEP_W'(1);
    seed_byte_idx = (seed_step < seed_plen) ? seed_step[2:0] : seed_low_idx[2:0];
    seed_byte     = prefix_chars[8*seed_byte_idx +: 8];
    if (seed_step < seed_plen) begin
      seed_sym = {2'b00, seed_byte[7:5]};
    end else if (seed_step == seed_plen) begin
      seed_sym = 5'd0;
    end else begin
      seed_sym = seed_byte[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      seed_busy   <= 1'b1;
      seed_step   <= '0;
      prefix_seed <= 30'd1;
    end else if (seed_busy) begin
      prefix_seed <= poly_step(prefix_seed, seed_sym);
      seed_step   <= seed_step + SEED_STEP_W'(1);
      if (seed_step == (seed_plen << 1)) begin
        seed_busy <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Per-character decode step
  // --------------------------------------------------------------------------
  logic [CHAR_COUNT_W-1:0] char_count_next;
  logic [29:0]             checksum_acc_next;
  logic [4:0]              symbol_delay_next [DELAY_DEPTH];
  logic [DELAY_FILL_W-1:0] delay_fill_next;
  logic [11:0]             bit_acc_next;
  logic [3:0]              bit_count_next;
  logic [BYTE_COUNT_W-1:0] byte_count_next;
  logic                    error_flag_next;
  dst_item_t               result;
  symbol_t                 sym;
  logic [CHAR_COUNT_W-1:0] plen_wide;
  logic [4:0]              released;
  logic [3:0]              bit_count_sum;
  logic [7:0]              pad_mask;

  always_comb begin
    char_count_next   = char_count;
    checksum_acc_next = checksum_acc;
    symbol_delay_next = symbol_delay;
    delay_fill_next   = delay_fill;
    bit_acc_next      = bit_acc;
    bit_count_next    = bit_count;
    byte_count_next   = byte_count;
    error_flag_next   = error_flag;
    result            = '0;
    sym               = symbol_lookup(src_data.in_char);
    plen_wide         = CHAR_COUNT_W'(plen);
    released          = symbol_delay[0];
    bit_count_sum     = bit_count + 4'd5;
    pad_mask          = '0;

    if (char_count < CHAR_COUNT_W'(MAX_STRING_CHARS + 1)) begin
      char_count_next = char_count + CHAR_COUNT_W'(1);
    end

    if (char_count < plen_wide) begin
      // Prefix character: exact match against the configured byte.
      if (src_data.in_char != prefix_chars[8*char_count[2:0] +: 8]) begin
        error_flag_next = 1'b1;
      end
    end else if (char_count == plen_wide) begin
      if (src_data.in_char != SEPARATOR_CHAR) begin
        error_flag_next = 1'b1;
      end
      checksum_acc_next = prefix_seed;
    end else if (char_count < CHAR_COUNT_W'(MAX_STRING_CHARS)) begin
      if (!sym.hit) begin
        error_flag_next = 1'b1;
      end else begin
        checksum_acc_next = poly_step(checksum_acc, sym.value);
        if (delay_fill < DELAY_FILL_W'(DELAY_DEPTH)) begin
          // Fill the checksum holdback first.
          symbol_delay_next[delay_fill] = sym.value;
          delay_fill_next = delay_fill + DELAY_FILL_W'(1);
        end else begin
          // Release the oldest symbol and regroup 5-bit to 8-bit.
          for (int k = 0; k < DELAY_DEPTH - 1; k++) begin
            symbol_delay_next[k] = symbol_delay[k+1];
          end
          symbol_delay_next[DELAY_DEPTH-1] = sym.value;
          bit_acc_next   = {bit_acc[6:0], released};
          bit_count_next = bit_count_sum;
          if (bit_count_sum >= 4'd8) begin
            bit_count_next = bit_count_sum - 4'd8;
            if (byte_count >= max_out_bytes) begin
              error_flag_next = 1'b1;
            end else begin
              result.out_byte   = 8'(bit_acc_next >> bit_count_next);
              result.byte_valid = 1'b1;
              byte_count_next   = byte_count + BYTE_COUNT_W'(1);
            end
          end
        end
      end
    end

    if (src_data.end_of_string) begin
      pad_mask           = 8'((9'd1 << bit_count_next) - 9'd1);
      result.string_done = 1'b1;
      result.failed      = error_flag_next
                        || (char_count_next < plen_wide + CHAR_COUNT_W'(8))
                        || (char_count_next > CHAR_COUNT_W'(MAX_STRING_CHARS))
                        || (checksum_acc_next != 30'd1)
                        || (bit_count_next >= 4'd5)
                        || ((bit_acc_next[7:0] & pad_mask) != 8'd0)
                        || (byte_count_next == '0);
      // Return to the start-of-string state.
      char_count_next   = '0;
      checksum_acc_next = 30'd1;
      for (int k = 0; k < DELAY_DEPTH; k++) begin
        symbol_delay_next[k] = '0;
      end
      delay_fill_next = '0;
      bit_acc_next    = '0;
      bit_count_next  = '0;
      byte_count_next = '0;
      error_flag_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count   <= '0;
      checksum_acc <= 30'd1;
      for (int k = 0; k < DELAY_DEPTH; k++) begin
        symbol_delay[k] <= '0;
      end
      delay_fill <= '0;
      bit_acc    <= '0;
      bit_count  <= '0;
      byte_count <= '0;
      error_flag <= 1'b0;
    end else if (accept) begin
      char_count   <= char_count_next;
      checksum_acc <= checksum_acc_next;
      symbol_delay <= symbol_delay_next;
      delay_fill   <= delay_fill_next;
      bit_acc      <= bit_acc_next;
      bit_count    <= bit_count_next;
      byte_count   <= byte_count_next;
      error_flag   <= error_flag_next;
    end
  end

  // --------------------------------------------------------------------------
  // Two-entry result queue: push on accept, drop on dst transfer.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      out_slot[wr_ptr] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= 1'b0;
      rd_ptr    <= 1'b0;
      out_count <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({accept, pop})
        2'b10:   out_count <= out_count + 2'd1;
        2'b01:   out_count <= out_count - 2'd1;
        default: out_count <= out_count;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_queue_bound : assert property (@(posedge clk) disable iff (rst)
    (out_count <= 2'd2) && ((out_count == 2'd1) == (wr_ptr != rd_ptr)))
    else $error("result queue count and pointers disagree");

  a_seed_blocks_input : assert property (@(posedge clk) disable iff (rst)
    seed_busy |-> !accept)
    else $error("character taken while prefix seed is being computed");

  a_end_clears : assert property (@(posedge clk) disable iff (rst)
    (accept && src_data.end_of_string) |=>
      (char_count == '0 && !error_flag && delay_fill == '0 && byte_count == '0))
    else $error("string state not cleared after last character");

  a_regroup_bounds : assert property (@(posedge clk) disable iff (rst)
    (bit_count <= 4'd7) && (delay_fill <= DELAY_FILL_W'(DELAY_DEPTH)))
    else $error("bit regroup or holdback fill out of range");

  a_byte_needs_fill : assert property (@(posedge clk) disable iff (rst)
    (accept && result.byte_valid) |-> (delay_fill == DELAY_FILL_W'(DELAY_DEPTH)))
    else $error("byte emitted before checksum holdback filled");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming bech32 string decoder. Strings are
// built with correct checksums and padding for the programmed prefix, then
// damaged in various ways or replaced by noise. A cycle-level predictor tracks
// the decoder state and checks every result transfer in order.
// ----------------------------------------------------------------------------
module tb_top;
  import bech32d_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;

  // Data alphabet, symbol 0 in the top byte.
  localparam logic [8*32-1:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  localparam logic [29:0] GENERATOR [5] = '{
    30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
  };

  // Ways a generated string is damaged on purpose.
  typedef enum int {
    STR_CLEAN,
    STR_PAD_BITS,      // nonzero padding, or a whole symbol of padding
    STR_EXTRA_SYMBOL,  // one more data symbol than the bytes need
    STR_TYPO,          // one character swapped for another alphabet character
    STR_RANDOM_BYTE,   // one character replaced by any byte
    STR_BAD_SEP,       // separator replaced
    STR_UPPER          // one data character in upper case
  } str_kind_t;

  // Clock, reset and DUT inputs, all known from time zero.
  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       src_valid = 1'b0;
  src_item_t  src_data  = '0;
  logic       dst_stall = 1'b0;
  logic       cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_PREFIX_CHARS;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  logic       src_stall;
  logic       dst_valid;
  dst_item_t  dst_data;

  always #5 clk = ~clk;

  bech32_string_decoder_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Checksum and alphabet helpers shared by the predictor and the generator
  // --------------------------------------------------------------------------
  function automatic logic [29:0] bch_fold(input logic [29:0] acc, input logic [4:0] v);
    logic [29:0] r;
    r = {acc[24:0], v};
    for (int j = 0; j < 5; j++) begin
      if (acc[25 + j]) begin
        r = r ^ GENERATOR[j];
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] sym_char(input logic [4:0] s);
    return CHARSET[8 * (31 - s) +: 8];
  endfunction

  // -1 when the character is outside the alphabet.
  function automatic int char_to_sym(input logic [7:0] c);
    for (int i = 0; i < 32; i++) begin
      if (sym_char(5'(i)) == c) begin
        return i;
      end
    end
    return -1;
  endfunction

  // --------------------------------------------------------------------------
  // Decoder predictor and result scoreboard
  // --------------------------------------------------------------------------
  class bech32_tracker;
    logic [63:0] pfx_chars;
    logic [3:0]  pfx_len;
    logic [12:0] max_bytes;

    logic [29:0] seed;
    logic [29:0] chk;
    int unsigned char_count;
    logic [4:0]  held [DELAY_DEPTH];
    int unsigned fill;
    logic [11:0] bits;
    int unsigned nbits;
    int unsigned byte_count;
    bit          err;

    dst_item_t   due_results [$];

    int unsigned failures;
    int unsigned strings_seen;
    int unsigned strings_good;
    int unsigned bytes_seen;

    function new();
      pfx_chars = '0;
      pfx_len   = 4'd1;
      max_bytes = 13'd4096;
      refresh_seed();
      clear_string();
    endfunction

    function int unsigned prefix_used();
      return (pfx_len > PREFIX_MAX_CHARS) ? PREFIX_MAX_CHARS : pfx_len;
    endfunction

    function logic [7:0] prefix_char(input int unsigned i);
      return pfx_chars[8 * (i % 8) +: 8];
    endfunction

    function void refresh_seed();
      logic [29:0] acc;
      int unsigned n;
      n   = prefix_used();
      acc = 30'd1;
      for (int unsigned i = 0; i < n; i++) acc = bch_fold(acc, 5'(prefix_char(i) >> 5));
      acc = bch_fold(acc, 5'd0);
      for (int unsigned i = 0; i < n; i++) acc = bch_fold(acc, 5'(prefix_char(i)));
      seed = acc;
    endfunction

    function void clear_string();
      chk         = 30'd1;
      char_count  = 0;
      fill        = 0;
      bits        = '0;
      nbits       = 0;
      byte_count  = 0;
      err         = 1'b0;
      foreach (held[i]) held[i] = '0;
    endfunction

    // Registers take effect at once; every write to a known register reloads the prefix seed.
    function void load_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
      case (idx)
        CFG_PREFIX_CHARS:  pfx_chars = val;
        CFG_PREFIX_LENGTH: pfx_len   = val[3:0];
        CFG_MAX_OUT_BYTES: max_bytes = val[12:0];
        default:           return;
      endcase
      refresh_seed();
    endfunction

    // Note one accepted character and queue the result it must produce.
    function void absorb_char(input src_item_t item);
      int unsigned pos;
      int unsigned plen;
      int          s;
      logic [4:0]  rel;
      dst_item_t   e;
      e    = '0;
      plen = prefix_used();
      pos  = char_count;
      if (char_count < MAX_STRING_CHARS + 1) char_count++;

      if (pos < plen) begin
        if (item.in_char != prefix_char(pos)) err = 1'b1;
      end else if (pos == plen) begin
        if (item.in_char != SEPARATOR_CHAR) err = 1'b1;
        chk = seed;
      end else if (pos < MAX_STRING_CHARS) begin
        s = char_to_sym(item.in_char);
        if (s < 0) begin
          err = 1'b1;
        end else begin
          chk = bch_fold(chk, 5'(s));
          if (fill < DELAY_DEPTH) begin
            held[fill] = 5'(s);
            fill++;
          end else begin
            // Oldest symbol leaves the checksum window and joins the byte stream.
            rel = held[0];
            for (int i = 0; i < DELAY_DEPTH - 1; i++) held[i] = held[i + 1];
            held[DELAY_DEPTH - 1] = 5'(s);
            bits  = {bits[6:0], rel};
            nbits += 5;
            if (nbits >= 8) begin
              nbits -= 8;
              if (byte_count >= max_bytes) begin
                err = 1'b1;
              end else begin
                e.out_byte   = 8'(bits >> nbits);
                e.byte_valid = 1'b1;
                byte_count++;
              end
            end
          end
        end
      end

      if (item.end_of_string) begin
        e.string_done = 1'b1;
        e.failed = err || (char_count < plen + 8) || (char_count > MAX_STRING_CHARS) ||
                   (chk != 30'd1) || (nbits >= 5) ||
                   ((bits & ((12'd1 << nbits) - 1)) != 0) || (byte_count == 0);
        strings_seen++;
        if (!e.failed) strings_good++;
        clear_string();
      end
      if (e.byte_valid) bytes_seen++;
      due_results.push_back(e);
    endfunction

    function void compare_result(input dst_item_t got);
      dst_item_t want;
      if (due_results.size() == 0) begin
        $error("result transfer with nothing outstanding: %p", got);
        failures++;
        return;
      end
      want = due_results.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte expected %0h actual %0h", want.out_byte, got.out_byte);
        failures++;
      end
      if (got.byte_valid !== want.byte_valid) begin
        $error("byte_valid expected %0b actual %0b", want.byte_valid, got.byte_valid);
        failures++;
      end
      if (got.string_done !== want.string_done) begin
        $error("string_done expected %0b actual %0b", want.string_done, got.string_done);
        failures++;
      end
      if (got.failed !== want.failed) begin
        $error("failed expected %0b actual %0b", want.failed, got.failed);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction
  endclass

  bech32_tracker tracker;

  int unsigned items_sent;
  int unsigned settings_count;
  int unsigned quiet_cycles;
  bit          idle_on = 1'b1;
  logic [7:0]  str_buf [$];

  // --------------------------------------------------------------------------
  // Monitor: both channels sampled at the edge where the transfer happens.
  // The watchdog trips when neither channel moves for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (src_valid && !src_stall) tracker.absorb_char(src_data);
      if (dst_valid && !dst_stall) tracker.compare_result(dst_data);
      if ((src_valid && !src_stall) || (dst_valid && !dst_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[bench] no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("[bech32_string_decoder_core] ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: stall in random bursts, none when idling is switched off for
  // the last part of the run.
  // --------------------------------------------------------------------------
  int stall_left;

  always @(posedge clk) begin
    if (rst || !idle_on) begin
      dst_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left--;  // hold the stall
    end else if ($urandom_range(0, 7) == 0) begin
      dst_stall  <= 1'b1;
      stall_left = $urandom_range(0, 9);
    end else begin
      dst_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Character source
  // --------------------------------------------------------------------------

  // Present one character and hold it until the transfer; sometimes drop
  // valid for a burst first.
  task automatic send_item(input src_item_t item);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_data  <= item;
    do @(posedge clk); while (src_stall !== 1'b0);
    items_sent++;
  endtask

  // Send the buffered string, end_of_string on its last character.
  task automatic send_string();
    src_item_t item;
    foreach (str_buf[i]) begin
      item.in_char       = str_buf[i];
      item.end_of_string = (i == str_buf.size() - 1);
      send_item(item);
    end
  endtask

  // Build a string for the current prefix that carries nbytes of payload,
  // then damage it as kind says.
  task automatic build_string(input int nbytes, input str_kind_t kind);
    logic [4:0]  syms [$];
    logic [7:0]  hrp [$];
    logic [29:0] chk;
    logic [7:0]  c;
    int          acc;
    int          nb;
    int          plen;
    int          pos;
    plen = tracker.prefix_used();
    for (int i = 0; i < plen; i++) hrp.push_back(tracker.prefix_char(i));

    // Regroup 8-bit bytes into 5-bit symbols, zero padding at the end.
    acc = 0;
    nb  = 0;
    repeat (nbytes) begin
      acc = ((acc << 8) | $urandom_range(0, 255)) & 'h1fff;
      nb  += 8;
      while (nb >= 5) begin
        nb -= 5;
        syms.push_back(5'(acc >> nb));
      end
    end
    if (nb > 0) syms.push_back(5'(acc << (5 - nb)));

    if (kind == STR_PAD_BITS) begin
      if (nb > 0) syms[syms.size() - 1] = syms[syms.size() - 1] | 5'd1;
      else syms.push_back(5'($urandom_range(1, 31)));
    end else if (kind == STR_EXTRA_SYMBOL) begin
      syms.push_back(5'($urandom_range(0, 31)));
    end

    // Checksum over expanded prefix and data, so a clean string ends at one.
    chk = 30'd1;
    foreach (hrp[i]) chk = bch_fold(chk, 5'(hrp[i] >> 5));
    chk = bch_fold(chk, 5'd0);
    foreach (hrp[i]) chk = bch_fold(chk, hrp[i][4:0]);
    foreach (syms[i]) chk = bch_fold(chk, syms[i]);
    repeat (6) chk = bch_fold(chk, 5'd0);
    chk = chk ^ 30'd1;
    for (int i = 0; i < 6; i++) syms.push_back(chk[5 * (5 - i) +: 5]);

    str_buf.delete();
    foreach (hrp[i]) str_buf.push_back(hrp[i]);
    str_buf.push_back(SEPARATOR_CHAR);
    foreach (syms[i]) str_buf.push_back(sym_char(syms[i]));

    case (kind)
      STR_TYPO: begin
        pos = $urandom_range(0, str_buf.size() - 1);
        do c = sym_char(5'($urandom_range(0, 31))); while (c == str_buf[pos]);
        str_buf[pos] = c;
      end
      STR_RANDOM_BYTE: begin
        pos = $urandom_range(0, str_buf.size() - 1);
        str_buf[pos] = 8'($urandom_range(0, 255));
      end
      STR_BAD_SEP: begin
        do c = 8'($urandom_range(0, 255)); while (c == SEPARATOR_CHAR);
        str_buf[plen] = c;
      end
      STR_UPPER: begin
        pos = $urandom_range(plen + 1, str_buf.size() - 1);
        if (str_buf[pos] >= "a" && str_buf[pos] <= "z") str_buf[pos] = str_buf[pos] - 8'h20;
        else str_buf[pos] = "B";
      end
      default: ;
    endcase
  endtask

  // Random junk with end_of_string at a random point: mixes alphabet
  // characters with arbitrary bytes.
  task automatic build_noise();
    str_buf.delete();
    repeat ($urandom_range(1, 20)) begin
      if ($urandom_range(0, 1) == 0) str_buf.push_back(sym_char(5'($urandom_range(0, 31))));
      else str_buf.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Mostly short payloads, a few medium ones, and the odd empty one.
  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r < 3) return $urandom_range(13, 60);
    return $urandom_range(1, 12);
  endfunction

  // Random strings until the phase has moved its share of characters.
  task automatic run_phase(input int unsigned budget);
    int unsigned start;
    int          pick;
    start = items_sent;
    while (items_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        build_noise();
      end else if (pick < 60) begin
        build_string(pick_size(), STR_CLEAN);
      end else begin
        build_string(pick_size(),
                     str_kind_t'($urandom_range(int'(STR_PAD_BITS), int'(STR_UPPER))));
      end
      send_string();
    end
  endtask

  // Drain, then program all three registers back to back. Unused upper data
  // bits carry junk that the block must drop.
  task automatic configure(input logic [63:0] chars, input logic [3:0] len,
                           input logic [12:0] max_out);
    src_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_PREFIX_CHARS;
    cfg_data  <= chars;
    @(posedge clk);
    tracker.load_reg(CFG_PREFIX_CHARS, chars);
    cfg_index <= CFG_PREFIX_LENGTH;
    cfg_data  <= {$urandom(), 28'($urandom()), len};
    @(posedge clk);
    tracker.load_reg(CFG_PREFIX_LENGTH, cfg_data);
    cfg_index <= CFG_MAX_OUT_BYTES;
    cfg_data  <= {$urandom(), 19'($urandom()), max_out};
    @(posedge clk);
    tracker.load_reg(CFG_MAX_OUT_BYTES, cfg_data);
    cfg_write <= 1'b0;
    settings_count++;
  endtask

  function automatic logic [63:0] lower_prefix();
    logic [63:0] v;
    for (int i = 0; i < 8; i++) v[8 * i +: 8] = 8'($urandom_range("a", "z"));
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    tracker = new();
    settings_count = 1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: one-character prefix of byte zero. A clean one-byte
    // string, a lone 0xff that ends at once, and a string with an upper-case
    // data character.
    build_string(1, STR_CLEAN);
    send_string();
    str_buf = {8'hff};
    send_string();
    build_string(1, STR_UPPER);
    send_string();

    // Empty prefix.
    configure(lower_prefix(), 4'd0, 13'd4096);
    run_phase(100);
    // Longest prefix.
    configure(lower_prefix(), 4'd8, 13'd4096);
    run_phase(100);
    // Length above range saturates; arbitrary prefix bytes; one byte allowed.
    configure({$urandom(), $urandom()}, 4'd15, 13'd1);
    run_phase(100);
    // All-ones prefix bytes and no bytes allowed at all.
    configure(64'hffff_ffff_ffff_ffff, 4'd3, 13'd0);
    run_phase(90);
    // Just over the prefix range, small byte limit around typical payloads.
    configure({$urandom(), $urandom()}, 4'd9, 13'($urandom_range(2, 12)));
    run_phase(100);
    // Largest limit the register holds.
    configure(lower_prefix(), 4'($urandom_range(1, 8)), 13'h1fff);
    run_phase(100);

    // Last part: no idling on either side. A medium clean string, then
    // short random traffic.
    idle_on = 1'b0;
    configure(lower_prefix(), 4'd2, 13'd4096);
    build_string(40, STR_CLEAN);
    send_string();
    run_phase(80);

    src_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d characters in %0d strings (%0d decoded, %0d rejected), %0d bytes",
             items_sent, tracker.strings_seen, tracker.strings_good,
             tracker.strings_seen - tracker.strings_good, tracker.bytes_seen);
    $display("across %0d register settings, %0d mismatches", settings_count, tracker.failures);
    if (tracker.failures == 0) begin
      $display("[bech32_string_decoder_core] OK");
    end else begin
      $display("[bech32_string_decoder_core] ERROR");
    end
    $finish;
  end

endmodule

>>> bech32_string_decoder_core.f
hdl/bech32d_pkg.sv
hdl/bech32_string_decoder_core.sv
tb/tb_top.sv
